/* hw/rtl/ssem_pkg.sv */
// shared types and codes for the sequence store
// no dependencies; imported by the front end, back end, top level and checkers
package ssem_pkg;

    // operation codes carried in the op field of an input item
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_MID   = 3'd1,
        OP_INS_END   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_MID   = 3'd4,
        OP_DEL_END   = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // what the back end has to do with the store
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INS  = 2'd1,
        KIND_DEL  = 2'd2
    } t_kind;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SHIFT = 2'd1,
        BK_PLACE = 2'd2,
        BK_EMIT  = 2'd3
    } t_back_state;

    typedef struct packed {
        logic        [2:0]  op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] element;
        logic        [3:0]  position;
        logic               element_valid;
        logic        [4:0]  length;
        logic        [1:0]  status;
        logic               last;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic signed [31:0] value;
    } t_cmd;

endpackage

/* hw/rtl/ssem_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module ssem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ssem_front.sv */
// front end: accepts input items and classifies them into commands
// depends on ssem_pkg; keeps a shadow of the element count
module ssem_front #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssem_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output ssem_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_at,
    output logic [CW-1:0]     o_pre
);

    import ssem_pkg::*;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_at;
    t_kind         n_kind;
    t_status       n_status;
    logic          full;
    logic          empty;

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // decode op into kind, status and target index
    always_comb begin
        n_kind   = KIND_NONE;
        n_status = STAT_DONE;
        n_at     = '0;
        unique case (t_op'(i_in_data.op))
            OP_INS_FRONT, OP_INS_MID, OP_INS_END: begin
                if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_kind = KIND_INS;
                    if (t_op'(i_in_data.op) == OP_INS_MID) begin
                        n_at = r_count >> 1;
                    end else if (t_op'(i_in_data.op) == OP_INS_END) begin
                        n_at = r_count;
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_MID, OP_DEL_END: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_kind = KIND_DEL;
                    if (t_op'(i_in_data.op) == OP_DEL_MID) begin
                        n_at = r_count >> 1;
                    end else if (t_op'(i_in_data.op) == OP_DEL_END) begin
                        n_at = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_kind = KIND_NONE;
            end
        endcase
    end

    // count after this command
    always_comb begin
        n_count = r_count;
        if (n_kind == KIND_INS) begin
            n_count = r_count + CW'(1);
        end else if (n_kind == KIND_DEL) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    assign o_cmd.kind   = n_kind;
    assign o_cmd.status = n_status;
    assign o_cmd.value  = i_in_data.value;
    assign o_at         = n_at[AW-1:0];
    assign o_pre        = r_count;

endmodule

/* hw/rtl/ssem_queue.sv */
// two-entry command queue between front and back
// no dependencies
module ssem_queue #(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hw/rtl/ssem_back.sv */
// back end: shifts the store in memory and streams the sequence out
// depends on ssem_pkg and ssem_ram
module ssem_back #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_pop,
    input  ssem_pkg::t_cmd     i_cmd,
    input  logic [AW-1:0]      i_at,
    input  logic [CW-1:0]      i_pre,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssem_pkg::t_out_item o_out_data
);

    import ssem_pkg::*;

    t_back_state r_state, n_state;
    t_kind       r_kind, n_kind;
    t_status     r_status, n_status;
    logic signed [31:0] r_value, n_value;
    logic [AW-1:0] r_at, n_at;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_src, n_src;
    logic          r_wpend, n_wpend;
    logic [AW-1:0] r_widx, n_widx;
    logic [CW-1:0] r_emit_idx, n_emit_idx;
    logic          r_rd_vld, n_rd_vld;
    logic [CW-1:0] r_rd_pos, n_rd_pos;
    logic          r_rd_last, n_rd_last;
    logic          r_rd_ev, n_rd_ev;
    logic          r_out_vld, n_out_vld;
    t_out_item     r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          load_out;
    logic          adv;
    logic          emit_last;
    logic [CW-1:0] at_ext;
    logic [CW+3:0] pos_ext;
    logic [CW+4:0] len_ext;

    ssem_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read stage feeds the output register
    assign load_out  = r_rd_vld && (!r_out_vld || !i_out_stall);
    assign adv       = !r_rd_vld || load_out;
    assign emit_last = (r_cnt == '0) || ((r_emit_idx + CW'(1)) == r_cnt);
    assign at_ext    = CW'(i_at);
    assign pos_ext   = {4'b0, r_rd_pos};
    assign len_ext   = {5'b0, r_cnt};

    // sequencer next state and memory control
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_status   = r_status;
        n_value    = r_value;
        n_at       = r_at;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_src      = r_src;
        n_wpend    = r_wpend;
        n_widx     = r_widx;
        n_emit_idx = r_emit_idx;
        n_rd_vld   = r_rd_vld;
        n_rd_pos   = r_rd_pos;
        n_rd_last  = r_rd_last;
        n_rd_ev    = r_rd_ev;
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_widx;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = r_src[AW-1:0];

        if (load_out) begin
            n_rd_vld = 1'b0;
        end

        // finish the move whose read was issued last cycle
        if (r_wpend) begin
            ram_we  = 1'b1;
            n_wpend = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !r_rd_vld) begin
                    o_pop      = 1'b1;
                    n_kind     = i_cmd.kind;
                    n_status   = i_cmd.status;
                    n_value    = i_cmd.value;
                    n_at       = i_at;
                    n_emit_idx = '0;
                    n_cnt      = i_pre;
                    n_left     = '0;
                    n_src      = '0;
                    n_state    = BK_EMIT;
                    if (i_cmd.kind == KIND_INS) begin
                        n_cnt   = i_pre + CW'(1);
                        n_left  = i_pre - at_ext;
                        n_src   = i_pre - CW'(1);
                        n_state = BK_SHIFT;
                    end else if (i_cmd.kind == KIND_DEL) begin
                        n_cnt   = i_pre - CW'(1);
                        n_left  = i_pre - CW'(1) - at_ext;
                        n_src   = at_ext + CW'(1);
                        n_state = BK_SHIFT;
                    end
                end
            end
            BK_SHIFT: begin
                if (r_left != '0) begin
                    ram_re  = 1'b1;
                    n_left  = r_left - CW'(1);
                    n_wpend = 1'b1;
                    if (r_kind == KIND_INS) begin
                        n_widx = r_src[AW-1:0] + AW'(1);
                        n_src  = r_src - CW'(1);
                    end else begin
                        n_widx = r_src[AW-1:0] - AW'(1);
                        n_src  = r_src + CW'(1);
                    end
                end else if (!r_wpend) begin
                    n_state = (r_kind == KIND_INS) ? BK_PLACE : BK_EMIT;
                end
            end
            BK_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_at;
                ram_wdata = r_value;
                n_state   = BK_EMIT;
            end
            BK_EMIT: begin
                if (adv) begin
                    ram_re     = (r_cnt != '0);
                    ram_raddr  = r_emit_idx[AW-1:0];
                    n_rd_vld   = 1'b1;
                    n_rd_pos   = r_emit_idx;
                    n_rd_ev    = (r_cnt != '0);
                    n_rd_last  = emit_last;
                    n_emit_idx = r_emit_idx + CW'(1);
                    if (emit_last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (load_out) begin
            n_out_vld             = 1'b1;
            n_out.element         = r_rd_ev ? $signed(ram_rdata) : 32'sd0;
            n_out.position        = pos_ext[3:0];
            n_out.element_valid   = r_rd_ev;
            n_out.length          = len_ext[4:0];
            n_out.status          = r_status;
            n_out.last            = r_rd_last;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_wpend   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wpend   <= n_wpend;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_status   <= n_status;
        r_value    <= n_value;
        r_at       <= n_at;
        r_cnt      <= n_cnt;
        r_left     <= n_left;
        r_src      <= n_src;
        r_widx     <= n_widx;
        r_emit_idx <= n_emit_idx;
        r_rd_pos   <= n_rd_pos;
        r_rd_last  <= n_rd_last;
        r_rd_ev    <= n_rd_ev;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/sequence_store_end_mid_ops.sv */
// top level of the sequence store: front end, command queue, back end
// depends on ssem_pkg, ssem_front, ssem_queue, ssem_back
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// an item takes its command from the queue, moves the shifted elements in the memory
// shift loop, places an inserted value, then reads out one result per element (one
// result for an empty store) and frees the read stage; up to DEPTH-1 elements move,
// one at a time through the single write and read port of the store memory.
// reset clears the element count; store contents are unknown until written.
// the front takes up to two items ahead into the queue while the back works,
// and out stalls hold the output and read stages and pause the emit sequence.
module sequence_store_end_mid_ops #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssem_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ssem_pkg::t_out_item o_out_data
);

    import ssem_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = $bits(t_cmd) + AW + CW;

    t_cmd          f_cmd;
    logic [AW-1:0] f_at;
    logic [CW-1:0] f_pre;
    logic          f_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    t_cmd          b_cmd;
    logic [AW-1:0] b_at;
    logic [CW-1:0] b_pre;

    ssem_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_cmd      (f_cmd),
        .o_at       (f_at),
        .o_pre      (f_pre)
    );

    ssem_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_at, f_pre}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {b_cmd, b_at, b_pre} = q_data;

    ssem_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_pop       (q_pop),
        .i_cmd       (b_cmd),
        .i_at        (b_at),
        .i_pre       (b_pre),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/ssem_checker.sv */
// port-level checks for the sequence store, bound to the top level
// depends on ssem_pkg and sequence_store_end_mid_ops
module ssem_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  ssem_pkg::t_in_item  i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  ssem_pkg::t_out_item o_out_data
);

    import ssem_pkg::*;

    logic out_xfer;
    assign out_xfer = o_out_valid && !i_out_stall;

    // stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a run never breaks: the next result follows right after a non-final transfer
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_out_data.last |=> o_out_valid)
        else $error("gap inside a result run");

    // positions count up and length and status stay fixed within a run
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_out_data.last |=>
            (o_out_data.position == 4'($past(o_out_data.position) + 4'd1)) &&
            (o_out_data.length == $past(o_out_data.length)) &&
            (o_out_data.status == $past(o_out_data.status)))
        else $error("result run out of order");

    // an empty result is the only result of its run
    a_empty_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.element_valid |->
            o_out_data.last && (o_out_data.length == 5'd0) &&
            (o_out_data.position == 4'd0))
        else $error("malformed empty result");

endmodule

bind sequence_store_end_mid_ops ssem_checker u_ssem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* sim/seq_store_checker.sv */
`timescale 1ns / 1ps
// transfer monitor, sequence predictor and result comparator for the sequence store
// depends on ssem_pkg; instantiated beside the block by tb_sequence_store_end_mid_ops
module seq_store_checker #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  ssem_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  ssem_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import ssem_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // predicted sequence contents, front at index 0
    logic signed [31:0] seq_mem [DEPTH];
    int unsigned        seq_len;

    // snapshot rows still owed by the block, oldest first
    t_out_item          snapshot_rows [$];
    int                 mismatch_total;

    // count a failure, print only the first few
    task automatic note_failure(input string msg);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT) begin
            $display("[%0t] mismatch %0d: %s", $realtime, mismatch_total, msg);
        end
    endtask

    // apply one operation to the predicted sequence and queue its snapshot
    task automatic apply_seq_op(input t_in_item itm);
        t_status     st;
        int unsigned slot;
        int unsigned k;
        t_out_item   row;
        st   = STAT_DONE;
        slot = 0;
        case (itm.op)
            OP_INS_FRONT, OP_INS_MID, OP_INS_END: begin
                if (seq_len >= DEPTH) begin
                    st = STAT_FULL;
                end else begin
                    if (itm.op == OP_INS_MID) slot = seq_len / 2;
                    else if (itm.op == OP_INS_END) slot = seq_len;
                    for (k = seq_len; k > slot; k--) seq_mem[k] = seq_mem[k - 1];
                    seq_mem[slot] = itm.value;
                    seq_len++;
                end
            end
            OP_DEL_FRONT, OP_DEL_MID, OP_DEL_END: begin
                if (seq_len == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    if (itm.op == OP_DEL_MID) slot = seq_len / 2;
                    else if (itm.op == OP_DEL_END) slot = seq_len - 1;
                    for (k = slot; k + 1 < seq_len; k++) seq_mem[k] = seq_mem[k + 1];
                    seq_len--;
                end
            end
            default: ;
        endcase

        // empty store gives one row without an element
        if (seq_len == 0) begin
            row               = '0;
            row.status        = st;
            row.last          = 1'b1;
            snapshot_rows.push_back(row);
        end else begin
            for (k = 0; k < seq_len; k++) begin
                row.element       = seq_mem[k];
                row.position      = k[3:0];
                row.element_valid = 1'b1;
                row.length        = seq_len[4:0];
                row.status        = st;
                row.last          = (k + 1 == seq_len);
                snapshot_rows.push_back(row);
            end
        end
    endtask

    // compare one output transfer against the oldest owed row
    task automatic check_row(input t_out_item got);
        t_out_item want;
        if (snapshot_rows.size() == 0) begin
            note_failure($sformatf("unexpected result elem=%0d pos=%0d ev=%0b len=%0d st=%0d last=%0b",
                got.element, got.position, got.element_valid, got.length, got.status, got.last));
        end else begin
            want = snapshot_rows.pop_front();
            if (got.element !== want.element || got.position !== want.position ||
                got.element_valid !== want.element_valid || got.length !== want.length ||
                got.status !== want.status || got.last !== want.last) begin
                note_failure($sformatf({"expected elem=%0d pos=%0d ev=%0b len=%0d st=%0d last=%0b",
                    " got elem=%0d pos=%0d ev=%0b len=%0d st=%0d last=%0b"},
                    want.element, want.position, want.element_valid, want.length, want.status,
                    want.last, got.element, got.position, got.element_valid, got.length,
                    got.status, got.last));
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_len = 0;
            snapshot_rows.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_row(i_out_data);
            if (i_in_valid && !i_in_stall) apply_seq_op(i_in_data);
        end
        o_pending    = snapshot_rows.size();
        o_fail_count = mismatch_total;
    end

endmodule

/* sim/tb_sequence_store_end_mid_ops.sv */
`timescale 1ns / 1ps
// stimulus top for the sequence store: clock, reset, operation traffic, output stalls, verdict
// depends on ssem_pkg, sequence_store_end_mid_ops and seq_store_checker
module tb_sequence_store_end_mid_ops;
    import ssem_pkg::*;

    localparam int          SEQ_DEPTH      = 16;
    localparam int          RANDOM_ITEMS   = 400;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 60;
    localparam logic [2:0]  OP_UNDEF_LO    = 3'd6;
    localparam logic [2:0]  OP_UNDEF_HI    = 3'd7;

    // traffic mix of a random phase
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_EVERY3 = 3;
    localparam int STALL_LONG   = 4;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_data;
    int         fail_count;
    int         pending;
    int unsigned idle_cycles;
    int         stall_mode;
    int unsigned stall_left;

    sequence_store_end_mid_ops #(
        .DEPTH(SEQ_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    seq_store_checker #(
        .DEPTH(SEQ_DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stall pattern, switched at random intervals
    initial begin
        out_stall  = 1'b0;
        stall_mode = STALL_NONE;
        stall_left = 100;
    end

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_LONG);
            stall_left <= $urandom_range(40, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            STALL_EVERY3: out_stall <= (stall_left % 3 == 0);
            default:      out_stall <= ((stall_left % 32) < 20);
        endcase
    end

    // watchdog on cycles without any transfer
    initial idle_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // present one item from a falling edge and hold it until the transfer
    task automatic send_item(input logic [2:0] op, input logic signed [31:0] value);
        in_data  <= {op, value};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // hold the input until every owed result has come out
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // value mix: extremes, small signed, full random
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5:    return $signed($urandom_range(0, 511)) - 32'sd256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_insert();
        case ($urandom_range(0, 2))
            0:       return OP_INS_FRONT;
            1:       return OP_INS_MID;
            default: return OP_INS_END;
        endcase
    endfunction

    function automatic logic [2:0] pick_delete();
        case ($urandom_range(0, 2))
            0:       return OP_DEL_FRONT;
            1:       return OP_DEL_MID;
            default: return OP_DEL_END;
        endcase
    endfunction

    // operation biased by the current phase mix
    function automatic logic [2:0] pick_op(input int mix);
        int unsigned r;
        int unsigned ins_share;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL) ins_share = 80;
        else if (mix == MIX_DRAIN) ins_share = 20;
        else ins_share = 50;
        if (r < 4) return ($urandom_range(0, 1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
        else if (r < 4 + ins_share * 96 / 100) return pick_insert();
        else return pick_delete();
    endfunction

    // main stimulus
    initial begin
        int sent;
        int burst;
        int gap;
        int mix;
        int k;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // deletes on the empty store
        send_item(OP_DEL_FRONT, 32'sd11);
        send_item(OP_DEL_MID, 32'sd12);
        send_item(OP_DEL_END, 32'sd13);
        // middle operations on short sequences
        send_item(OP_INS_MID, 32'sh7fff_ffff);
        send_item(OP_DEL_MID, 32'sd0);
        send_item(OP_INS_MID, 32'sh8000_0000);
        send_item(OP_INS_MID, -32'sd1);
        // undefined codes leave the sequence alone
        send_item(OP_UNDEF_LO, 32'sh5555_5555);
        send_item(OP_UNDEF_HI, 32'shaaaa_aaaa);
        // fill to capacity, then inserts against a full store
        for (k = 0; k < SEQ_DEPTH - 2; k++) begin
            case (k % 3)
                0:       send_item(OP_INS_FRONT, pick_value());
                1:       send_item(OP_INS_MID, pick_value());
                default: send_item(OP_INS_END, pick_value());
            endcase
        end
        send_item(OP_INS_FRONT, 32'sh7fff_ffff);
        send_item(OP_INS_MID, 32'sh8000_0000);
        send_item(OP_INS_END, 32'sd0);
        pause_until_drained();

        // random phases of fill, drain and balanced traffic in bursts
        sent = 0;
        mix  = MIX_DRAIN;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) mix = $urandom_range(MIX_FILL, MIX_EVEN);
            burst = $urandom_range(1, 16);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_item(pick_op(mix), pick_value());
                sent++;
                if (sent % 100 == 0) pause_until_drained();
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        // wait for the tail, then a little longer for stray results
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
